// ===== hdl/wsd_pkg.sv =====
// package with phase codes and the result word type of the websocket deframer
`default_nettype none
package wsd_pkg;

    localparam int unsigned LEN_W   = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned COUNT_W = 4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [COUNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [COUNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [COUNT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic              header_valid;
        logic              fin;
        logic [2:0]        reserved_bits;
        logic [3:0]        frame_opcode;
        logic              masked;
        logic [LEN_W-1:0]  payload_length;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_offset;
        logic              frame_end;
        logic              slice_end;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/wsd_if.sv =====
// stream interfaces for raw input bytes and deframer result words
`default_nettype none
interface wsd_in_if;
    logic                     valid;
    logic                     ready;
    logic [wsd_pkg::BYTE_W-1:0] data_byte;
    logic                     chunk_last;

    modport source (output valid, output data_byte, output chunk_last, input ready);
    modport sink (input valid, input data_byte, input chunk_last, output ready);
endinterface

interface wsd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      header_valid;
    logic                      fin;
    logic [2:0]                reserved_bits;
    logic [3:0]                frame_opcode;
    logic                      masked;
    logic [wsd_pkg::LEN_W-1:0]  payload_length;
    logic                      payload_valid;
    logic [wsd_pkg::BYTE_W-1:0] payload_byte;
    logic [wsd_pkg::LEN_W-1:0]  payload_offset;
    logic                      frame_end;
    logic                      slice_end;

    modport source (
        output valid, output header_valid, output fin, output reserved_bits,
        output frame_opcode, output masked, output payload_length,
        output payload_valid, output payload_byte, output payload_offset,
        output frame_end, output slice_end, input ready
    );
    modport sink (
        input valid, input header_valid, input fin, input reserved_bits,
        input frame_opcode, input masked, input payload_length,
        input payload_valid, input payload_byte, input payload_offset,
        input frame_end, input slice_end, output ready
    );
endinterface
`default_nettype wire

// ===== hdl/wsd_parser.sv =====
// header parser state and payload unmasking, one byte per accepted word
`default_nettype none
module wsd_parser #(
    parameter int unsigned LENGTH_BITS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_chunk_last,
    output wsd_pkg::t_result     o_result,
    output logic                 o_emit
);
    import wsd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic                   r_fin, n_fin;
    logic [2:0]             r_rsv, n_rsv;
    logic [3:0]             r_opcode, n_opcode;
    logic                   r_mask_en, n_mask_en;
    logic [LENGTH_BITS-1:0] r_length, n_length;
    logic [LENGTH_BITS-1:0] r_offset, n_offset;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [1:0]             r_mphase, n_mphase;

    logic                   w_len_done;
    logic                   w_hdr_done;
    logic                   w_frame_end;
    logic [BYTE_W-1:0]      w_key_byte;
    logic                   w_mask_en;
    logic [LENGTH_BITS-1:0] w_offset_inc;

    assign w_mask_en = (r_phase == PH_SECOND) ? i_data_byte[7] : r_mask_en;

    // completion flags of the header sequence
    always_comb begin
        w_len_done = 1'b0;
        w_hdr_done = 1'b0;
        case (r_phase)
            PH_SECOND: begin
                w_len_done = (i_data_byte[6:0] != LEN_EXT16) && (i_data_byte[6:0] != LEN_EXT64);
            end
            PH_EXTLEN: begin
                w_len_done = (r_count == COUNT_W'(1));
            end
            PH_KEY: begin
                w_hdr_done = (r_count == COUNT_W'(1));
            end
            default: begin
            end
        endcase
        if (w_len_done && !w_mask_en) begin
            w_hdr_done = 1'b1;
        end
    end

    assign w_offset_inc = r_offset + LENGTH_BITS'(1);
    assign w_frame_end  = (w_offset_inc >= r_length);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_fin     = r_fin;
        n_rsv     = r_rsv;
        n_opcode  = r_opcode;
        n_mask_en = r_mask_en;
        n_length  = r_length;
        n_offset  = r_offset;
        n_key     = r_key;
        n_mphase  = r_mphase;
        case (r_phase)
            PH_SECOND: begin
                n_mask_en = i_data_byte[7];
                if (i_data_byte[6:0] == LEN_EXT16) begin
                    n_count  = EXT16_BYTES;
                    n_length = '0;
                    n_phase  = PH_EXTLEN;
                end else if (i_data_byte[6:0] == LEN_EXT64) begin
                    n_count  = EXT64_BYTES;
                    n_length = '0;
                    n_phase  = PH_EXTLEN;
                end else begin
                    n_length = LENGTH_BITS'(i_data_byte[6:0]);
                end
            end
            PH_EXTLEN: begin
                n_length = {r_length[LENGTH_BITS-9:0], i_data_byte};
                n_count  = r_count - COUNT_W'(1);
            end
            PH_KEY: begin
                n_key   = {r_key[KEY_W-9:0], i_data_byte};
                n_count = r_count - COUNT_W'(1);
            end
            PH_PAYLOAD: begin
                n_mphase = r_mphase + 2'd1;
                n_offset = w_offset_inc;
                if (w_frame_end) begin
                    n_phase = PH_FIRST;
                end
            end
            default: begin
                n_fin    = i_data_byte[7];
                n_rsv    = i_data_byte[6:4];
                n_opcode = i_data_byte[3:0];
                n_phase  = PH_SECOND;
            end
        endcase
        if (w_len_done && n_mask_en) begin
            n_phase = PH_KEY;
            n_count = KEY_BYTES;
            n_key   = '0;
        end
        if (w_hdr_done) begin
            n_offset = '0;
            n_mphase = 2'd0;
            n_count  = '0;
            n_phase  = (n_length == '0) ? PH_FIRST : PH_PAYLOAD;
        end
    end

    always_comb begin
        case (r_mphase)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    // result word
    always_comb begin
        o_emit                  = w_hdr_done || (r_phase == PH_PAYLOAD);
        o_result                = '0;
        o_result.fin            = n_fin;
        o_result.reserved_bits  = n_rsv;
        o_result.frame_opcode   = n_opcode;
        o_result.masked         = n_mask_en;
        o_result.payload_length = LEN_W'(n_length);
        if (r_phase == PH_PAYLOAD) begin
            o_result.payload_valid  = 1'b1;
            o_result.payload_byte   = r_mask_en ? (i_data_byte ^ w_key_byte) : i_data_byte;
            o_result.payload_offset = LEN_W'(n_offset);
            o_result.frame_end      = w_frame_end;
            o_result.slice_end      = w_frame_end || i_chunk_last;
        end else begin
            o_result.header_valid = w_hdr_done;
            o_result.frame_end    = w_hdr_done && (n_length == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIRST;
            r_count   <= '0;
            r_fin     <= 1'b0;
            r_rsv     <= '0;
            r_opcode  <= '0;
            r_mask_en <= 1'b0;
            r_length  <= '0;
            r_offset  <= '0;
            r_key     <= '0;
            r_mphase  <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_fin     <= n_fin;
            r_rsv     <= n_rsv;
            r_opcode  <= n_opcode;
            r_mask_en <= n_mask_en;
            r_length  <= n_length;
            r_offset  <= n_offset;
            r_key     <= n_key;
            r_mphase  <= n_mphase;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/wsd_out_reg.sv =====
// result register that drives the output stream
`default_nettype none
module wsd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wsd_pkg::t_result      i_result,
    output logic                  o_can_load,
    wsd_out_if.source             o_out
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.header_valid   = r_data.header_valid;
    assign o_out.fin            = r_data.fin;
    assign o_out.reserved_bits  = r_data.reserved_bits;
    assign o_out.frame_opcode   = r_data.frame_opcode;
    assign o_out.masked         = r_data.masked;
    assign o_out.payload_length = r_data.payload_length;
    assign o_out.payload_valid  = r_data.payload_valid;
    assign o_out.payload_byte   = r_data.payload_byte;
    assign o_out.payload_offset = r_data.payload_offset;
    assign o_out.frame_end      = r_data.frame_end;
    assign o_out.slice_end      = r_data.slice_end;

endmodule
`default_nettype wire

// ===== hdl/websocket_frame_deframer_unit.sv =====
// websocket frame deframer top level
// latency: a result word appears in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle while the output stream does not stall, set by the single parser state update
// input ready stays high while the result register is empty or being drained
// reset: synchronous active low, parser waits for a first header byte, no word held
`default_nettype none
module websocket_frame_deframer_unit #(
    parameter int unsigned LENGTH_BITS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wsd_in_if.sink     i_in,
    wsd_out_if.source  o_out
);
    import wsd_pkg::*;

    logic    w_take;
    logic    w_emit;
    logic    w_can_load;
    t_result w_result;

    assign i_in.ready = w_can_load;
    assign w_take     = i_in.valid && w_can_load;

    wsd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_data_byte  (i_in.data_byte),
        .i_chunk_last (i_in.chunk_last),
        .o_result     (w_result),
        .o_emit       (w_emit)
    );

    wsd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take && w_emit),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
